FILE: hw/rtl/bgm_pkg.sv
// Package: command, result-kind and register codes for the boost group tracker.
package bgm_pkg;

    localparam int CMD_W   = 3;
    localparam int BOOST_W = 8;
    localparam int MAX_W   = 7;
    localparam int KIND_W  = 2;
    localparam int TIME_W  = 64;
    localparam int HOLD_W  = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CMD_W-1:0] CMD_ENQUEUE   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DEQUEUE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SET_BOOST = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MOVE      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_CLEAR     = 3'd5;

    localparam logic [KIND_W-1:0] KIND_UNCHANGED  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RAISED     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RECOMPUTED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_ALL  = 2'd1;

    localparam logic [HOLD_W-1:0] HOLD_RESET = 32'd50000000;

    typedef logic signed [BOOST_W-1:0] boost_t;

endpackage

FILE: hw/rtl/boost_group_max_with_hold.sv
// Top level: boost group table with held maximum, one shared time comparator.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall  | command, group, dest_group, new_boost,
//          |           |                      | now, task_is_realtime
//  out     | output    | out_valid / out_stall| peak_boost, update_kind
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Sequence: one command occupies the block from its transfer until its result is
// loaded into the output register: an execute step, then a walk of the table when a
// recompute is needed (one group per cycle through the shared 64-bit subtract and
// compare), a move or a clear step for a valid move or a clear, and a done step.
// Reset clears the table, the held maximum and the control registers to defaults.
// A stalled result holds in the output register; the next command is taken
// while it waits, and its own result waits until the register frees up.
module boost_group_max_with_hold #(
    parameter int GROUPS     = 6,
    parameter int COUNT_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,

    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [bgm_pkg::CMD_W-1:0]        command,
    input  logic [2:0]                       group,
    input  logic [2:0]                       dest_group,
    input  logic signed [bgm_pkg::BOOST_W-1:0] new_boost,
    input  logic [bgm_pkg::TIME_W-1:0]       now,
    input  logic                             task_is_realtime,

    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [bgm_pkg::MAX_W-1:0]        peak_boost,
    output logic [bgm_pkg::KIND_W-1:0]       update_kind,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bgm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bgm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import bgm_pkg::*;

    localparam int GW   = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CMPW = GW + 4;
    localparam logic [GW-1:0]         LAST_GROUP = GW'(GROUPS - 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] COUNT_ONE  = COUNT_BITS'(1);

    // sequencer codes
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_MOVE = 3'd3;
    localparam logic [2:0] S_CLR  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg, state_next;

    // configuration
    logic [HOLD_W-1:0] hold_time_reg;
    logic              hold_all_reg;

    // latched command
    logic [CMD_W-1:0]  cmd_reg;
    logic [2:0]        grp_reg;
    logic [2:0]        dst_reg;
    boost_t            nb_reg;
    logic [TIME_W-1:0] now_reg;
    logic              rt_reg;

    // group table, one access address per cycle
    boost_t                boost_reg [GROUPS];
    logic [COUNT_BITS-1:0] tasks_reg [GROUPS];
    logic [TIME_W-1:0]     stamp_reg [GROUPS];

    // held maximum
    logic [MAX_W-1:0]  cur_max_reg, cur_max_next;
    logic [TIME_W-1:0] max_stamp_reg, max_stamp_next;

    // walk state
    logic [GW-1:0]     walk_reg, walk_next;
    boost_t            run_max_reg, run_max_next;
    logic [TIME_W-1:0] run_stamp_reg, run_stamp_next;
    logic [KIND_W-1:0] kind_reg, kind_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [MAX_W-1:0]  peak_boost_reg, peak_boost_next;
    logic [KIND_W-1:0] update_kind_reg, update_kind_next;

    logic              in_xfer;
    logic [GW-1:0]     addr;
    boost_t            boost_rd;
    logic [COUNT_BITS-1:0] tasks_rd;
    logic [TIME_W-1:0] stamp_rd;

    logic [TIME_W-1:0] unit_op;
    logic [TIME_W-1:0] unit_diff;
    logic              unit_expired;

    logic              grp_ok;
    logic              dst_ok;
    logic              entry_active;
    boost_t            bnew;
    boost_t            cur_s;
    logic [COUNT_BITS-1:0] tasks_inc;
    logic [COUNT_BITS-1:0] tasks_dec;

    logic                  wr_boost_en, wr_tasks_en, wr_stamp_en;
    boost_t                wr_boost_val;
    logic [COUNT_BITS-1:0] wr_tasks_val;
    logic [TIME_W-1:0]     wr_stamp_val;

    assign in_xfer   = in_valid && !in_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign out_valid   = out_valid_reg;
    assign peak_boost  = peak_boost_reg;
    assign update_kind = update_kind_reg;

    assign grp_ok = ({{(CMPW-3){1'b0}}, grp_reg} < CMPW'(GROUPS));
    assign dst_ok = ({{(CMPW-3){1'b0}}, dst_reg} < CMPW'(GROUPS)) && (dst_reg != grp_reg);

    // pick the one table entry this cycle works on
    always_comb
    begin
        case (state_reg)
            S_WALK:  addr = walk_reg;
            S_MOVE:  addr = GW'(dst_reg);
            default: addr = GW'(grp_reg);
        endcase
    end

    assign boost_rd = boost_reg[addr];
    assign tasks_rd = tasks_reg[addr];
    assign stamp_rd = stamp_reg[addr];

    // shared time unit: elapsed time against the hold, or now minus the hold for a move
    always_comb
    begin
        if (state_reg == S_MOVE)
            unit_op = {{(TIME_W-HOLD_W){1'b0}}, hold_time_reg};
        else if (state_reg == S_EXEC && cmd_reg == CMD_QUERY)
            unit_op = max_stamp_reg;
        else
            unit_op = stamp_rd;
    end

    assign unit_diff    = now_reg - unit_op;
    assign unit_expired = (unit_diff > {{(TIME_W-HOLD_W){1'b0}}, hold_time_reg});
    assign entry_active = (tasks_rd != '0) || !unit_expired;

    assign tasks_inc = (tasks_rd == COUNT_MAX) ? tasks_rd : tasks_rd + COUNT_ONE;
    assign tasks_dec = (tasks_rd == '0) ? tasks_rd : tasks_rd - COUNT_ONE;
    assign bnew      = (cmd_reg == CMD_CLEAR) ? boost_t'(0) : nb_reg;
    assign cur_s     = boost_t'({1'b0, cur_max_reg});

    always_comb
    begin
        state_next       = state_reg;
        cur_max_next     = cur_max_reg;
        max_stamp_next   = max_stamp_reg;
        walk_next        = walk_reg;
        run_max_next     = run_max_reg;
        run_stamp_next   = run_stamp_reg;
        kind_next        = kind_reg;
        out_valid_next   = out_valid_reg && out_stall;
        peak_boost_next  = peak_boost_reg;
        update_kind_next = update_kind_reg;
        wr_boost_en      = 1'b0;
        wr_tasks_en      = 1'b0;
        wr_stamp_en      = 1'b0;
        wr_boost_val     = bnew;
        wr_tasks_val     = tasks_inc;
        wr_stamp_val     = now_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_EXEC;
                    kind_next  = KIND_UNCHANGED;
                end
            end

            S_EXEC:
            begin
                state_next = S_DONE;
                walk_next  = '0;
                if (grp_ok)
                begin
                    case (cmd_reg)
                        CMD_ENQUEUE:
                        begin
                            wr_tasks_en  = 1'b1;
                            wr_tasks_val = tasks_inc;
                            wr_stamp_en  = rt_reg || hold_all_reg;
                            if (tasks_inc == COUNT_ONE)
                            begin
                                kind_next  = KIND_RECOMPUTED;
                                state_next = S_WALK;
                            end
                        end
                        CMD_DEQUEUE:
                        begin
                            wr_tasks_en  = 1'b1;
                            wr_tasks_val = tasks_dec;
                        end
                        CMD_SET_BOOST, CMD_CLEAR:
                        begin
                            wr_boost_en = 1'b1;
                            if (bnew > cur_s && entry_active)
                            begin
                                // raise in place, adopt the group's stamp
                                cur_max_next   = bnew[MAX_W-1:0];
                                max_stamp_next = stamp_rd;
                                kind_next      = KIND_RAISED;
                            end
                            else if (cur_s == boost_rd && boost_rd > bnew)
                            begin
                                kind_next  = KIND_RECOMPUTED;
                                state_next = S_WALK;
                            end
                            if (cmd_reg == CMD_CLEAR && state_next == S_DONE)
                                state_next = S_CLR;
                        end
                        CMD_QUERY:
                        begin
                            if (unit_expired)
                            begin
                                kind_next  = KIND_RECOMPUTED;
                                state_next = S_WALK;
                            end
                        end
                        CMD_MOVE:
                        begin
                            if (dst_ok)
                            begin
                                wr_tasks_en  = 1'b1;
                                wr_tasks_val = tasks_dec;
                                state_next   = S_MOVE;
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_WALK:
            begin
                // group 0 seeds the running maximum, the rest must be active
                run_max_next   = run_max_reg;
                run_stamp_next = run_stamp_reg;
                if (walk_reg == '0)
                begin
                    run_max_next   = boost_rd;
                    run_stamp_next = now_reg;
                end
                else if (entry_active && !(run_max_reg > boost_rd))
                begin
                    run_max_next   = boost_rd;
                    run_stamp_next = stamp_rd;
                end
                if (walk_reg == LAST_GROUP)
                begin
                    cur_max_next   = run_max_next[BOOST_W-1] ? '0 : run_max_next[MAX_W-1:0];
                    max_stamp_next = run_stamp_next;
                    state_next     = (cmd_reg == CMD_CLEAR) ? S_CLR : S_DONE;
                end
                else
                begin
                    walk_next = walk_reg + GW'(1);
                end
            end

            S_MOVE:
            begin
                wr_tasks_en    = 1'b1;
                wr_tasks_val   = tasks_inc;
                wr_stamp_en    = 1'b1;
                max_stamp_next = unit_diff;
                state_next     = S_DONE;
            end

            S_CLR:
            begin
                wr_tasks_en  = 1'b1;
                wr_tasks_val = '0;
                wr_stamp_en  = 1'b1;
                wr_stamp_val = '0;
                state_next   = S_DONE;
            end

            S_DONE:
            begin
                // hold the result until the output register frees up
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next   = 1'b1;
                    peak_boost_next  = cur_max_reg;
                    update_kind_next = kind_reg;
                    state_next       = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hold_time_reg <= HOLD_RESET;
            hold_all_reg  <= 1'b0;
            cur_max_reg   <= '0;
            max_stamp_reg <= '0;
            out_valid_reg <= 1'b0;
            walk_reg      <= '0;
            kind_reg      <= KIND_UNCHANGED;
            for (int i = 0; i < GROUPS; i++)
            begin
                boost_reg[i] <= '0;
                tasks_reg[i] <= '0;
                stamp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cur_max_reg   <= cur_max_next;
            max_stamp_reg <= max_stamp_next;
            out_valid_reg <= out_valid_next;
            walk_reg      <= walk_next;
            kind_reg      <= kind_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_HOLD_TIME)
                    hold_time_reg <= cfg_data[HOLD_W-1:0];
                else if (cfg_index == CFG_HOLD_ALL)
                    hold_all_reg <= cfg_data[0];
            end
            if (wr_boost_en)
                boost_reg[addr] <= wr_boost_val;
            if (wr_tasks_en)
                tasks_reg[addr] <= wr_tasks_val;
            if (wr_stamp_en)
                stamp_reg[addr] <= wr_stamp_val;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg <= command;
            grp_reg <= group;
            dst_reg <= dest_group;
            nb_reg  <= new_boost;
            now_reg <= now;
            rt_reg  <= task_is_realtime;
        end
        run_max_reg     <= run_max_next;
        run_stamp_reg   <= run_stamp_next;
        peak_boost_reg  <= peak_boost_next;
        update_kind_reg <= update_kind_next;
    end

    // a result only appears when the sequencer finishes a command
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_DONE)
        else $error("result appeared outside the done step");

    // a transfer always starts execution on the next cycle
    a_xfer_exec: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> state_reg == S_EXEC)
        else $error("accepted command did not start");

    // the held maximum never moves while the block is idle
    a_max_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |=> $stable(cur_max_reg))
        else $error("maximum changed while idle");

    // the walk index stays inside the table
    a_walk_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WALK |-> walk_reg <= LAST_GROUP)
        else $error("walk index out of range");

endmodule

FILE: sim/tb_boost_group_max_with_hold.sv
// Testbench for the boost group tracker: directed, register and random traffic against a predictor.
`timescale 1ns / 100ps

module tb_boost_group_max_with_hold;

    import bgm_pkg::*;

    // Block configuration and the table size the predictor mirrors.
    localparam int GROUPS     = 6;
    localparam int COUNT_BITS = 16;
    localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

    // Command codes the package leaves unnamed; the block must treat them as no-ops.
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

    // Register indexes that address nothing; writes to them must leave the block alone.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    localparam int CLK_HIGH    = 4;
    localparam int CLK_LOW     = 4;
    localparam int RESET_CYCLES = 9;
    localparam int LONG_HOLD   = 400;      // receiver hold-off during the backpressure test
    localparam int SETTLE      = 20;       // cycles after the last result before the verdict
    localparam int CYCLE_LIMIT = 400000;   // well above the slowest legal run

    typedef struct packed {
        logic [MAX_W-1:0]  peak;
        logic [KIND_W-1:0] kind;
    } peak_result_t;

    // ------------------------------------------------------------------
    // DUT signals; every input starts at a known value
    // ------------------------------------------------------------------
    logic                clk              = 1'b0;
    logic                rst_n            = 1'b0;
    logic                in_valid         = 1'b0;
    logic [CMD_W-1:0]    command          = '0;
    logic [2:0]          group            = '0;
    logic [2:0]          dest_group       = '0;
    boost_t              new_boost        = '0;
    logic [TIME_W-1:0]   now              = '0;
    logic                task_is_realtime = 1'b0;
    logic                out_stall        = 1'b0;
    logic                cfg_valid        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    logic                in_stall;
    logic                out_valid;
    logic [MAX_W-1:0]    peak_boost;
    logic [KIND_W-1:0]   update_kind;
    logic                cfg_ready;

    boost_group_max_with_hold #(
        .GROUPS     (GROUPS),
        .COUNT_BITS (COUNT_BITS)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .group            (group),
        .dest_group       (dest_group),
        .new_boost        (new_boost),
        .now              (now),
        .task_is_realtime (task_is_realtime),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .peak_boost       (peak_boost),
        .update_kind      (update_kind),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #CLK_LOW  clk = 1'b1;
        #CLK_HIGH clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the group table and registers
    // ------------------------------------------------------------------
    boost_t              tbl_boost [GROUPS];
    logic [COUNT_BITS-1:0] tbl_tasks [GROUPS];
    logic [TIME_W-1:0]   tbl_stamp [GROUPS];
    logic [MAX_W-1:0]    held_peak;
    logic [TIME_W-1:0]   held_stamp;
    logic [HOLD_W-1:0]   reg_hold;
    logic                reg_hold_all;

    peak_result_t        peak_results_q [$];   // expected results, oldest first

    int                  err_count     = 0;
    int                  cycle_count   = 0;
    int                  send_idle_pct = 0;    // chance of a sender idle cycle, in percent
    int                  stall_pct     = 0;    // chance of a receiver stall cycle, in percent
    logic [TIME_W-1:0]   sim_now       = '0;   // running clock time for random traffic
    logic [2:0]          last_grp      = '0;

    // Long hold-off: the test flips hold_kick, this process counts the stretch down.
    logic                hold_kick     = 1'b0;
    logic                kick_seen     = 1'b0;
    int                  hold_left     = 0;

    function automatic void reset_tracker();
        int g;
        for (g = 0; g < GROUPS; g++)
        begin
            tbl_boost[g] = '0;
            tbl_tasks[g] = '0;
            tbl_stamp[g] = '0;
        end
        held_peak    = '0;
        held_stamp   = '0;
        reg_hold     = HOLD_RESET;
        reg_hold_all = 1'b0;
    endfunction

    // Hold has run out once the wrapped distance exceeds the hold length.
    function automatic logic hold_expired(input logic [TIME_W-1:0] t, input logic [TIME_W-1:0] ts);
        return (t - ts) > {32'b0, reg_hold};
    endfunction

    function automatic logic group_live(input int g, input logic [TIME_W-1:0] t);
        return (tbl_tasks[g] != '0) || !hold_expired(t, tbl_stamp[g]);
    endfunction

    // Walk the table: group 0 always counts, later live groups win ties.
    function automatic void rescan_peak(input logic [TIME_W-1:0] t);
        boost_t            m;
        logic [TIME_W-1:0] ts;
        int                g;
        m  = tbl_boost[0];
        ts = t;
        for (g = 1; g < GROUPS; g++)
        begin
            if (group_live(g, t) && !(m > tbl_boost[g]))
            begin
                m  = tbl_boost[g];
                ts = tbl_stamp[g];
            end
        end
        if (m < 0)
            m = '0;
        held_peak  = m[MAX_W-1:0];
        held_stamp = ts;
    endfunction

    // Replace one group's boost; raise directly, rescan, or leave the peak alone.
    function automatic logic [KIND_W-1:0] apply_boost(input int g, input boost_t b,
                                                      input logic [TIME_W-1:0] t);
        boost_t cur;
        boost_t old;
        cur          = $signed({1'b0, held_peak});
        old          = tbl_boost[g];
        tbl_boost[g] = b;
        if (b > cur && group_live(g, t))
        begin
            held_peak  = b[MAX_W-1:0];
            held_stamp = tbl_stamp[g];
            return KIND_RAISED;
        end
        if (cur == old && old > b)
        begin
            rescan_peak(t);
            return KIND_RECOMPUTED;
        end
        return KIND_UNCHANGED;
    endfunction

    // Advance the tracker by one command and return the result it must produce.
    function automatic peak_result_t track_command(input logic [CMD_W-1:0] cmd,
                                                   input logic [2:0] grp,
                                                   input logic [2:0] dst,
                                                   input boost_t nb,
                                                   input logic [TIME_W-1:0] t,
                                                   input logic rt);
        peak_result_t      r;
        int                g;
        int                d;
        logic [KIND_W-1:0] kind;
        g    = grp;
        d    = dst;
        kind = KIND_UNCHANGED;
        if (g < GROUPS)
        begin
            case (cmd)
                CMD_ENQUEUE:
                begin
                    if (tbl_tasks[g] != COUNT_TOP)
                        tbl_tasks[g] = tbl_tasks[g] + 1'b1;
                    if (rt || reg_hold_all)
                        tbl_stamp[g] = t;
                    if (tbl_tasks[g] == 1)
                    begin
                        rescan_peak(t);
                        kind = KIND_RECOMPUTED;
                    end
                end
                CMD_DEQUEUE:
                begin
                    if (tbl_tasks[g] != '0)
                        tbl_tasks[g] = tbl_tasks[g] - 1'b1;
                end
                CMD_SET_BOOST:
                    kind = apply_boost(g, nb, t);
                CMD_QUERY:
                begin
                    if (hold_expired(t, held_stamp))
                    begin
                        rescan_peak(t);
                        kind = KIND_RECOMPUTED;
                    end
                end
                CMD_MOVE:
                begin
                    if (d < GROUPS && d != g)
                    begin
                        if (tbl_tasks[g] != '0)
                            tbl_tasks[g] = tbl_tasks[g] - 1'b1;
                        if (tbl_tasks[d] != COUNT_TOP)
                            tbl_tasks[d] = tbl_tasks[d] + 1'b1;
                        tbl_stamp[d] = t;
                        held_stamp   = t - {32'b0, reg_hold};
                    end
                end
                CMD_CLEAR:
                begin
                    kind         = apply_boost(g, '0, t);
                    tbl_tasks[g] = '0;
                    tbl_stamp[g] = '0;
                end
                default: ;
            endcase
        end
        r.peak = held_peak;
        r.kind = kind;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_error(input string msg);
        $display("[cycle %0d] mismatch: %s", cycle_count, msg);
        err_count++;
    endtask

    // Compare every result transfer against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        peak_result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (peak_results_q.size() == 0)
                report_error("result transfer with no pending expectation");
            else
            begin
                exp_r = peak_results_q.pop_front();
                if (peak_boost !== exp_r.peak)
                    report_error($sformatf("peak_boost expected %0d got %0d",
                                           exp_r.peak, peak_boost));
                if (update_kind !== exp_r.kind)
                    report_error($sformatf("update_kind expected %0d got %0d",
                                           exp_r.kind, update_kind));
            end
        end
    end

    // Count down a long receiver hold-off each time the test flips hold_kick.
    always @(posedge clk)
    begin
        if (hold_kick != kick_seen)
        begin
            kick_seen <= hold_kick;
            hold_left <= LONG_HOLD;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Receiver: stall during a hold-off, otherwise at the phase's random rate.
    always @(posedge clk)
        out_stall <= rst_n && ((hold_left != 0) || ($urandom_range(99) < stall_pct));

    // Watchdog: end the run if the traffic never finishes.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, peak_results_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one command, optionally after idle cycles, and predict it on transfer.
    // Leave in_valid high afterwards so back-to-back commands never glitch it.
    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [2:0] grp,
                            input logic [2:0] dst, input boost_t nb,
                            input logic [TIME_W-1:0] t, input logic rt);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid         <= 1'b1;
        command          <= cmd;
        group            <= grp;
        dest_group       <= dst;
        new_boost        <= nb;
        now              <= t;
        task_is_realtime <= rt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        peak_results_q.push_back(track_command(cmd, grp, dst, nb, t, rt));
    endtask

    // Drop the input and wait until every expected result has been seen.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (peak_results_q.size() != 0);
    endtask

    // Write one register; hold cfg_valid high unless this is the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data, input logic last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (last)
            cfg_valid <= 1'b0;
        case (idx)
            CFG_HOLD_TIME: reg_hold     = data;
            CFG_HOLD_ALL:  reg_hold_all = data[0];
            default: ;
        endcase
    endtask

    // Build one random command. Time mostly advances in steps scaled to the hold,
    // often right at the hold boundary, sometimes past it, backwards or anywhere.
    task automatic send_random_cmd();
        logic [CMD_W-1:0]  cmd;
        logic [2:0]        grp;
        logic [2:0]        dst;
        boost_t            nb;
        logic [TIME_W-1:0] hold64;
        int                r;
        int                v;
        hold64 = {32'b0, reg_hold};
        r = $urandom_range(99);
        if (r < 55)
            sim_now = sim_now + ({$urandom, $urandom} % (hold64 / 4 + 64'd4));
        else if (r < 80)
            sim_now = sim_now + hold64 + 64'($urandom_range(2)) - 64'd1;
        else if (r < 92)
            sim_now = sim_now + hold64 + 64'd1 + 64'($urandom_range(100000));
        else if (r < 97)
            sim_now = {$urandom, $urandom};
        else
            sim_now = sim_now - 64'($urandom_range(1000, 1));

        r = $urandom_range(99);
        if (r < 24)
            cmd = CMD_ENQUEUE;
        else if (r < 44)
            cmd = CMD_DEQUEUE;
        else if (r < 64)
            cmd = CMD_SET_BOOST;
        else if (r < 78)
            cmd = CMD_QUERY;
        else if (r < 88)
            cmd = CMD_MOVE;
        else if (r < 96)
            cmd = CMD_CLEAR;
        else if (r < 98)
            cmd = CMD_UNUSED_LO;
        else
            cmd = CMD_UNUSED_HI;

        // Keep hitting the same group now and then so sequences build on each other.
        if ($urandom_range(99) < 30)
            grp = last_grp;
        else if ($urandom_range(99) < 94)
            grp = 3'($urandom_range(GROUPS - 1));
        else
            grp = 3'($urandom_range(7, GROUPS));
        if ($urandom_range(99) < 94)
            dst = 3'($urandom_range(GROUPS - 1));
        else
            dst = 3'($urandom_range(7, GROUPS));
        last_grp = grp;

        if ($urandom_range(99) < 85)
        begin
            v  = int'($urandom_range(200)) - 100;
            nb = v[BOOST_W-1:0];
        end
        else
            nb = 8'($urandom);

        send_cmd(cmd, grp, dst, nb, sim_now, 1'($urandom));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every command and the no-op corner cases, at reset settings.
    task automatic test_directed_extremes();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_cmd(CMD_QUERY,     3'd0, 3'd0, 8'sd0,    64'd0,   1'b0);
        send_cmd(CMD_ENQUEUE,   3'd5, 3'd0, 8'sd0,    64'd100, 1'b1);
        send_cmd(CMD_ENQUEUE,   3'd5, 3'd5, 8'sd0,    64'd200, 1'b0);
        // boost above the nominal range is taken as given
        send_cmd(CMD_SET_BOOST, 3'd5, 3'd0, 8'sh7F,   64'd300, 1'b0);
        send_cmd(CMD_SET_BOOST, 3'd0, 3'd0, 8'sh80,   64'd400, 1'b0);
        send_cmd(CMD_QUERY,     3'd0, 3'd7, 8'sh7F,   '1,      1'b1);
        send_cmd(CMD_DEQUEUE,   3'd5, 3'd0, 8'sd0,    64'd410, 1'b0);
        send_cmd(CMD_DEQUEUE,   3'd5, 3'd0, 8'sd0,    64'd420, 1'b0);
        // count already zero: saturate
        send_cmd(CMD_DEQUEUE,   3'd5, 3'd0, 8'sd0,    64'd430, 1'b0);
        // lower the group holding the peak: rescan, the live groups at zero boost set the peak to zero
        send_cmd(CMD_SET_BOOST, 3'd5, 3'd0, -8'sd100, 64'd500, 1'b0);
        send_cmd(CMD_SET_BOOST, 3'd4, 3'd0, 8'sd100,  64'd600, 1'b0);
        send_cmd(CMD_MOVE,      3'd2, 3'd3, 8'sd0,    64'd700, 1'b0);
        // move within one group and to an absent group: no-ops
        send_cmd(CMD_MOVE,      3'd3, 3'd3, 8'sd0,    64'd710, 1'b0);
        send_cmd(CMD_MOVE,      3'd1, 3'd7, 8'sd0,    64'd720, 1'b0);
        // out-of-range target groups: no-ops
        send_cmd(CMD_ENQUEUE,   3'd6, 3'd0, 8'sd0,    64'd730, 1'b1);
        send_cmd(CMD_SET_BOOST, 3'd7, 3'd0, 8'sd50,   64'd740, 1'b0);
        // unknown command codes: no-ops
        send_cmd(CMD_UNUSED_LO, 3'd1, 3'd2, 8'sd10,   64'd750, 1'b1);
        send_cmd(CMD_UNUSED_HI, 3'd1, 3'd2, 8'sd10,   64'd760, 1'b1);
        send_cmd(CMD_CLEAR,     3'd4, 3'd0, 8'sd0,    64'd770, 1'b0);
        send_cmd(CMD_QUERY,     3'd0, 3'd0, 8'sd0,    64'd50001000, 1'b0);
        send_cmd(CMD_ENQUEUE,   3'd0, 3'd7, 8'sh80,   64'hFFFF_FFFF_FFFF_FFF0, 1'b1);
        send_cmd(CMD_SET_BOOST, 3'd3, 3'd0, 8'sh80,   64'hFFFF_FFFF_FFFF_FFF8, 1'b0);
        send_cmd(CMD_CLEAR,     3'd3, 3'd0, 8'sd0,    64'd5,   1'b0);
    endtask

    // Writes to unused indexes and upper data bits must not disturb the registers.
    task automatic test_register_writes();
        drain_results();
        write_reg(CFG_SPARE_LO,  $urandom,      1'b0);
        write_reg(CFG_SPARE_HI,  '1,            1'b0);
        write_reg(CFG_HOLD_ALL,  32'hFFFF_FFFE, 1'b0);
        write_reg(CFG_HOLD_TIME, 32'd10,        1'b1);
        send_idle_pct = 0;
        stall_pct     = 0;
        // a non-realtime enqueue must not stamp the group while hold-all is off
        send_cmd(CMD_ENQUEUE,   3'd2, 3'd0, 8'sd0,  64'd1000, 1'b0);
        send_cmd(CMD_DEQUEUE,   3'd2, 3'd0, 8'sd0,  64'd1001, 1'b0);
        send_cmd(CMD_SET_BOOST, 3'd2, 3'd0, 8'sd40, 64'd1002, 1'b0);
        send_cmd(CMD_ENQUEUE,   3'd1, 3'd0, 8'sd0,  64'd1003, 1'b1);
        send_cmd(CMD_SET_BOOST, 3'd1, 3'd0, 8'sd60, 64'd1008, 1'b0);
        send_cmd(CMD_QUERY,     3'd0, 3'd0, 8'sd0,  64'd1014, 1'b0);
    endtask

    // Random traffic under one register setting and one idling pattern.
    task automatic test_random_traffic(input logic [HOLD_W-1:0] hold, input logic hold_all,
                                       input logic [TIME_W-1:0] start_time, input int n_cmds,
                                       input int idle_pct, input int stall_rate);
        drain_results();
        write_reg(CFG_HOLD_TIME, hold,              1'b0);
        write_reg(CFG_HOLD_ALL,  {31'b0, hold_all}, 1'b1);
        send_idle_pct = idle_pct;
        stall_pct     = stall_rate;
        sim_now       = start_time;
        repeat (n_cmds)
            send_random_cmd();
    endtask

    // Hold the receiver off for a long stretch while commands keep coming,
    // so the output register and the input side both back up.
    task automatic test_full_backpressure();
        drain_results();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_kick    <= ~hold_kick;
        repeat (24)
            send_random_cmd();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        reset_tracker();
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_extremes();
        test_register_writes();
        // no idling, short hold
        test_random_traffic(32'd200, 1'b0, 64'd1000, 300, 0, 0);
        // zero hold, stamp on every enqueue, sender mostly idle
        test_random_traffic(32'd0, 1'b1, 64'h8000_0000_0000_0000, 300, 81, 0);
        // longest hold, time wraps, receiver mostly stalled
        test_random_traffic('1, 1'b0, 64'hFFFF_FFF0_0000_0000, 300, 0, 81);
        // random hold, both sides idle now and then
        test_random_traffic(32'($urandom_range(5000, 1)), 1'b1, {$urandom, $urandom},
                            300, 14, 14);
        // back to the reset hold length, close to the wrap
        test_random_traffic(HOLD_RESET, 1'b0, 64'hFFFF_FFFF_F000_0000, 300, 14, 14);
        test_full_backpressure();

        drain_results();
        repeat (SETTLE)
            @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: boost_group_max_with_hold.f
hw/rtl/bgm_pkg.sv
hw/rtl/boost_group_max_with_hold.sv
sim/tb_boost_group_max_with_hold.sv
